// ===== sv/assert_macros.svh =====
// Assertion macros used by the controller of the centroid core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define VRC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Antecedent implies consequent in the following cycle.
`define VRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define VRC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define VRC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/vrc_pkg.sv =====
// Shared constants, types and helpers of the voxel region centroid core.
package vrc_pkg;

    localparam int MAX_DIM    = 1024;
    localparam int FRAC_BITS  = 8;
    localparam int CRD_W      = $clog2(MAX_DIM);
    localparam int DIM_W      = 11;
    localparam int MASK_W     = 16;
    localparam int VAL_W      = 16;
    localparam int SUM_W      = 40;
    localparam int COUNT_W    = 31;
    localparam int MEAN_W     = 18;
    localparam int DIVD_W     = SUM_W + FRAC_BITS;
    localparam int DIV_STEPS  = MEAN_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int AXES       = 3;

    typedef logic [CRD_W-1:0]   t_crd;
    typedef logic [DIM_W-1:0]   t_dim;
    typedef logic [SUM_W-1:0]   t_sum;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [MEAN_W-1:0]  t_mean;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_DEPTH  = 2'd2,
        REG_MASK   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic acc_en;    // accepted voxel: accumulate and advance counters
        logic div_load;  // latch sums into the divider lanes, clear sums
        logic div_step;  // one restoring-division step in every lane
        logic out_load;  // capture result into the output register
    } t_cmd;

    typedef struct packed {
        logic vol_end;   // current voxel is the last of the volume
    } t_status;

    // Last coordinate in use along one axis; zero counts as one, oversize clamps.
    function automatic t_crd last_coord(input t_dim dim);
        if (dim == '0) begin
            return '0;
        end else if (dim > t_dim'(MAX_DIM)) begin
            return t_crd'(MAX_DIM - 1);
        end else begin
            return t_crd'(dim - t_dim'(1));
        end
    endfunction

endpackage

// ===== sv/vrc_ctrl.sv =====
// Controller: voxel acceptance, division sequencing and result handshake.
`include "assert_macros.svh"

module vrc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  vrc_pkg::t_status i_status,
    output vrc_pkg::t_cmd    o_cmd
);
    import vrc_pkg::*;

    typedef enum logic [3:0] {
        S_ACC  = 4'b0001,
        S_LOAD = 4'b0010,
        S_DIV  = 4'b0100,
        S_WAIT = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_out_valid, n_out_valid;
    logic                accept;
    logic                out_free;

    assign o_in_ready  = (r_state == S_ACC);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid & o_in_ready;
    assign out_free    = ~r_out_valid | i_out_ready;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            S_ACC: begin
                o_cmd.acc_en = accept;
                if (accept && i_status.vol_end) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_WAIT;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // input closes for the division once the last voxel is taken
    `VRC_ASSERT_NEXT(a_end_stalls_input, i_clk, i_rst_n, accept && i_status.vol_end, !o_in_ready)
    // a new result never overwrites one still waiting
    `VRC_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, o_cmd.out_load, !r_out_valid || i_out_ready)
    `VRC_ASSERT_SAME(a_step_bound, i_clk, i_rst_n, r_state == S_DIV, r_step < STEP_W'(DIV_STEPS))
    // result is presented right after capture
    `VRC_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, o_cmd.out_load, o_out_valid)

endmodule

// ===== sv/vrc_dp.sv =====
// Datapath: configuration, raster counters, coordinate sums and divider lanes.
module vrc_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [vrc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [vrc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [vrc_pkg::VAL_W-1:0]           i_voxel_value,
    input  vrc_pkg::t_cmd                       i_cmd,
    output vrc_pkg::t_status                    o_status,
    output logic [vrc_pkg::MEAN_W-1:0]          o_mean_x,
    output logic [vrc_pkg::MEAN_W-1:0]          o_mean_y,
    output logic [vrc_pkg::MEAN_W-1:0]          o_mean_z,
    output logic [vrc_pkg::COUNT_W-1:0]         o_selected_count,
    output logic                                o_empty_region
);
    import vrc_pkg::*;

    t_dim                r_width, r_height, r_depth;
    logic [MASK_W-1:0]   r_mask;

    t_crd                r_col, r_row, r_slice;
    t_sum                r_sum [AXES];
    t_count              r_count;

    t_count              r_divisor;
    logic                r_empty;
    t_count              r_rem [AXES];
    t_mean               r_quo [AXES];
    t_count              n_rem [AXES];
    t_mean               n_quo [AXES];
    logic [DIVD_W-1:0]   dividend [AXES];
    logic [COUNT_W:0]    trial [AXES];

    t_mean               r_mean_x, r_mean_y, r_mean_z;
    t_count              r_out_count;
    logic                r_out_empty;

    t_crd                last_x, last_y, last_z;
    logic                row_end, slice_end, vol_end, sel;
    t_crd                crd [AXES];

    assign last_x    = last_coord(r_width);
    assign last_y    = last_coord(r_height);
    assign last_z    = last_coord(r_depth);
    assign row_end   = (r_col >= last_x);
    assign slice_end = row_end && (r_row >= last_y);
    assign vol_end   = slice_end && (r_slice >= last_z);
    assign sel       = |(i_voxel_value & r_mask);
    assign crd[0]    = r_col;
    assign crd[1]    = r_row;
    assign crd[2]    = r_slice;

    assign o_status.vol_end = vol_end;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= t_dim'(MAX_DIM);
            r_height <= t_dim'(MAX_DIM);
            r_depth  <= t_dim'(MAX_DIM);
            r_mask   <= MASK_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                REG_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                REG_DEPTH:  r_depth  <= i_cfg_data[DIM_W-1:0];
                REG_MASK:   r_mask   <= i_cfg_data[MASK_W-1:0];
                default:    r_mask   <= r_mask;
            endcase
        end
    end

    // raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_slice <= '0;
        end else if (i_cmd.acc_en) begin
            if (vol_end) begin
                r_col   <= '0;
                r_row   <= '0;
                r_slice <= '0;
            end else if (!row_end) begin
                r_col <= r_col + t_crd'(1);
            end else begin
                r_col <= '0;
                if (!slice_end) begin
                    r_row <= r_row + t_crd'(1);
                end else begin
                    r_row   <= '0;
                    r_slice <= r_slice + t_crd'(1);
                end
            end
        end
    end

    // sums hold through the last voxel, then clear when the divider takes them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_sum[a] <= '0;
            end
            r_count <= '0;
        end else if (i_cmd.div_load) begin
            for (int a = 0; a < AXES; a++) begin
                r_sum[a] <= '0;
            end
            r_count <= '0;
        end else if (i_cmd.acc_en && sel) begin
            for (int a = 0; a < AXES; a++) begin
                r_sum[a] <= r_sum[a] + t_sum'(crd[a]);
            end
            r_count <= r_count + t_count'(1);
        end
    end

    // restoring division, one quotient bit per step; the mean is below 2^MEAN_W,
    // so the dividend bits above MEAN_W start as a remainder already below the count
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            dividend[a] = DIVD_W'(r_sum[a]) << FRAC_BITS;
            trial[a]    = {r_rem[a], r_quo[a][MEAN_W-1]};
            if (trial[a] >= {1'b0, r_divisor}) begin
                n_rem[a] = t_count'(trial[a] - {1'b0, r_divisor});
                n_quo[a] = {r_quo[a][MEAN_W-2:0], 1'b1};
            end else begin
                n_rem[a] = t_count'(trial[a]);
                n_quo[a] = {r_quo[a][MEAN_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_divisor <= r_count;
            r_empty   <= (r_count == '0);
            for (int a = 0; a < AXES; a++) begin
                r_rem[a] <= t_count'(dividend[a] >> MEAN_W);
                r_quo[a] <= dividend[a][MEAN_W-1:0];
            end
        end else if (i_cmd.div_step) begin
            for (int a = 0; a < AXES; a++) begin
                r_rem[a] <= n_rem[a];
                r_quo[a] <= n_quo[a];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_mean_x    <= r_empty ? '0 : r_quo[0];
            r_mean_y    <= r_empty ? '0 : r_quo[1];
            r_mean_z    <= r_empty ? '0 : r_quo[2];
            r_out_count <= r_divisor;
            r_out_empty <= r_empty;
        end
    end

    assign o_mean_x         = r_mean_x;
    assign o_mean_y         = r_mean_y;
    assign o_mean_z         = r_mean_z;
    assign o_selected_count = r_out_count;
    assign o_empty_region   = r_out_empty;

endmodule

// ===== sv/voxel_region_centroid_core.sv =====
// Top level of the voxel region centroid core.
//
// Voxel values enter on i_in_valid / o_in_ready in raster order (x fastest,
// then y, then z); one transaction is accepted per cycle while a volume is
// being summed. Voxels whose value ANDed with the region mask is nonzero add
// their coordinates to three sums and bump a count.
// The last voxel of a volume starts the division: a load state and 18
// restoring steps, one quotient bit per cycle in three parallel lanes. The
// result (means with 8 fraction bits, count, empty flag) enters the output
// register once the division is done and the register is free, and is
// offered on o_out_valid / i_out_ready; the input stays closed until that
// capture. Accumulation of the next volume proceeds while a result waits;
// if the receiver stalls, the following result waits in the divider until
// the output register is free. Configuration (width, height, depth, mask)
// is written through i_cfg_we, i_cfg_idx and i_cfg_data, one register per
// cycle; the user must write it only while idle, and the block does not
// enforce this. Synchronous active-low reset clears counters, sums and
// handshake state and restores the dimensions to 1024 and the mask to 1.
module voxel_region_centroid_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [vrc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [vrc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [vrc_pkg::VAL_W-1:0]           i_voxel_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [vrc_pkg::MEAN_W-1:0]          o_mean_x,
    output logic [vrc_pkg::MEAN_W-1:0]          o_mean_y,
    output logic [vrc_pkg::MEAN_W-1:0]          o_mean_z,
    output logic [vrc_pkg::COUNT_W-1:0]         o_selected_count,
    output logic                                o_empty_region
);
    import vrc_pkg::*;

    t_cmd    cmd;
    t_status status;

    vrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    vrc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_voxel_value    (i_voxel_value),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_mean_x         (o_mean_x),
        .o_mean_y         (o_mean_y),
        .o_mean_z         (o_mean_z),
        .o_selected_count (o_selected_count),
        .o_empty_region   (o_empty_region)
    );

endmodule
